/* rtl/stwalk_pkg.sv */
`default_nettype none
package stwalk_pkg;

    // Field widths of the stream items and the configuration registers
    localparam int NumDims  = 3;
    localparam int IdxW     = 16;
    localparam int ExtFieldW = 16;
    localparam int CountW   = 48;
    localparam int OffW     = 50;
    localparam int SrcW     = 53;
    localparam int DstW     = 51;
    localparam int StrideW  = 32;
    localparam int BaseW    = 40;
    localparam int ExtRegW  = 48;
    localparam int RankW    = 2;
    localparam int EszW     = 4;
    localparam int ProdW    = IdxW + StrideW;
    localparam int CfgDataW = 64;
    localparam int CfgAddrW = 6;
    localparam int InDataW  = 48;
    localparam int OutDataW = 160;
    localparam int OutUserW = 2;
    localparam int QueueDepth = 2;

    // Register reset values
    localparam logic [RankW-1:0]   RankRst    = 2'd1;
    localparam logic [EszW-1:0]    ElemRst    = 4'd4;
    localparam logic [ExtRegW-1:0] ExtentsRst = 48'h0001_0001_0001;
    localparam logic [StrideW-1:0] StrideRst  = 32'd1;

    // Register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_RANK       = 3'd0,
        REG_ELEM_BYTES = 3'd1,
        REG_BASE       = 3'd2,
        REG_EXTENTS    = 3'd3,
        REG_STRIDE0    = 3'd4,
        REG_STRIDE1    = 3'd5,
        REG_STRIDE2    = 3'd6
    } reg_idx_t;

    typedef enum logic {
        REQ_NEXT      = 1'b0,
        REQ_TRANSLATE = 1'b1
    } req_t;

    // Configuration as seen by the datapath (element size already clamped)
    typedef struct packed {
        logic [RankW-1:0]                  rank;
        logic [EszW-1:0]                   esz;
        logic [BaseW-1:0]                  base;
        logic [NumDims-1:0][StrideW-1:0]   stride;
        logic                              contig;
    } cfg_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        req_t                            kind;
        logic                            last;
        logic [NumDims-1:0][IdxW-1:0]    idx;
        logic [CountW-1:0]               count;
    } item_t;

endpackage
`default_nettype wire

/* rtl/stwalk_cfg.sv */
`default_nettype none
module stwalk_cfg #(
    parameter int EXTENT_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [stwalk_pkg::CfgAddrW-1:0]        paddr,
    input  wire logic [stwalk_pkg::CfgDataW-1:0]        pwdata,
    output logic      [stwalk_pkg::CfgDataW-1:0]        prdata,
    output stwalk_pkg::cfg_t                            cfg,
    output logic [stwalk_pkg::NumDims-1:0][EXTENT_BITS-1:0] ext,
    output logic                                        restart
);

    logic [stwalk_pkg::RankW-1:0]   rank_reg,    rank_next;
    logic [stwalk_pkg::EszW-1:0]    elem_reg,    elem_next;
    logic [stwalk_pkg::BaseW-1:0]   base_reg,    base_next;
    logic [stwalk_pkg::ExtRegW-1:0] extents_reg, extents_next;
    logic [stwalk_pkg::NumDims-1:0][stwalk_pkg::StrideW-1:0] stride_reg, stride_next;
    logic [2*EXTENT_BITS-1:0]       prod_reg,    prod_next;
    logic                           wr_en;
    stwalk_pkg::reg_idx_t           sel;

    assign wr_en = psel && penable && pwrite;
    assign sel   = stwalk_pkg::reg_idx_t'(paddr[5:3]);

    // Decode the write
    always_comb
    begin
        rank_next    = rank_reg;
        elem_next    = elem_reg;
        base_next    = base_reg;
        extents_next = extents_reg;
        stride_next  = stride_reg;
        restart      = 1'b0;
        if (wr_en)
        begin
            restart = 1'b1;
            case (sel)
                stwalk_pkg::REG_RANK:       rank_next    = pwdata[stwalk_pkg::RankW-1:0];
                stwalk_pkg::REG_ELEM_BYTES: elem_next    = pwdata[stwalk_pkg::EszW-1:0];
                stwalk_pkg::REG_BASE:       base_next    = pwdata[stwalk_pkg::BaseW-1:0];
                stwalk_pkg::REG_EXTENTS:    extents_next = pwdata[stwalk_pkg::ExtRegW-1:0];
                stwalk_pkg::REG_STRIDE0:    stride_next[0] = pwdata[stwalk_pkg::StrideW-1:0];
                stwalk_pkg::REG_STRIDE1:    stride_next[1] = pwdata[stwalk_pkg::StrideW-1:0];
                stwalk_pkg::REG_STRIDE2:    stride_next[2] = pwdata[stwalk_pkg::StrideW-1:0];
                default:                    restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg    <= stwalk_pkg::RankRst;
            elem_reg    <= stwalk_pkg::ElemRst;
            base_reg    <= '0;
            extents_reg <= stwalk_pkg::ExtentsRst;
            for (int d = 0; d < stwalk_pkg::NumDims; d++)
            begin
                stride_reg[d] <= stwalk_pkg::StrideRst;
            end
            prod_reg    <= (2*EXTENT_BITS)'(1);
        end
        else
        begin
            rank_reg    <= rank_next;
            elem_reg    <= elem_next;
            base_reg    <= base_next;
            extents_reg <= extents_next;
            stride_reg  <= stride_next;
            prod_reg    <= prod_next;
        end
    end

    // Effective extents: low bits of each field, zero counts as one
    always_comb
    begin
        for (int d = 0; d < stwalk_pkg::NumDims; d++)
        begin
            ext[d] = extents_reg[stwalk_pkg::ExtFieldW*d +: EXTENT_BITS];
            if (ext[d] == '0)
            begin
                ext[d] = EXTENT_BITS'(1);
            end
        end
    end

    // Row-major stride of dim 0 at rank three, registered, so it follows the extent registers in the next cycle
    assign prod_next = ext[1] * ext[2];

    // Clamp element size and check for a contiguous layout
    always_comb
    begin
        cfg.rank   = rank_reg;
        cfg.base   = base_reg;
        cfg.stride = stride_reg;
        if (elem_reg == '0)
        begin
            cfg.esz = stwalk_pkg::EszW'(1);
        end
        else if (elem_reg > stwalk_pkg::EszW'(8))
        begin
            cfg.esz = stwalk_pkg::EszW'(8);
        end
        else
        begin
            cfg.esz = elem_reg;
        end
        case (rank_reg)
            2'd0: cfg.contig = 1'b1;
            2'd1: cfg.contig = (stride_reg[0] == stwalk_pkg::StrideW'(1));
            2'd2: cfg.contig = (stride_reg[1] == stwalk_pkg::StrideW'(1))
                            && (stride_reg[0] == stwalk_pkg::StrideW'(ext[1]));
            default: cfg.contig = (stride_reg[2] == stwalk_pkg::StrideW'(1))
                            && (stride_reg[1] == stwalk_pkg::StrideW'(ext[2]))
                            && (stride_reg[0] == stwalk_pkg::StrideW'(prod_reg));
        endcase
    end

    // Readback
    always_comb
    begin
        case (sel)
            stwalk_pkg::REG_RANK:       prdata = stwalk_pkg::CfgDataW'(rank_reg);
            stwalk_pkg::REG_ELEM_BYTES: prdata = stwalk_pkg::CfgDataW'(elem_reg);
            stwalk_pkg::REG_BASE:       prdata = stwalk_pkg::CfgDataW'(base_reg);
            stwalk_pkg::REG_EXTENTS:    prdata = stwalk_pkg::CfgDataW'(extents_reg);
            stwalk_pkg::REG_STRIDE0:    prdata = stwalk_pkg::CfgDataW'(stride_reg[0]);
            stwalk_pkg::REG_STRIDE1:    prdata = stwalk_pkg::CfgDataW'(stride_reg[1]);
            stwalk_pkg::REG_STRIDE2:    prdata = stwalk_pkg::CfgDataW'(stride_reg[2]);
            default:                    prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/stwalk_front.sv */
`default_nettype none
module stwalk_front #(
    parameter int EXTENT_BITS = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       s_axis_tvalid,
    output logic                                            s_axis_tready,
    input  wire logic [stwalk_pkg::InDataW-1:0]             s_axis_tdata,
    input  wire logic [0:0]                                 s_axis_tuser,
    input  wire logic [stwalk_pkg::RankW-1:0]               rank,
    input  wire logic [stwalk_pkg::NumDims-1:0][EXTENT_BITS-1:0] ext,
    input  wire logic                                       restart,
    input  wire logic                                       q_full,
    output logic                                            q_push,
    output stwalk_pkg::item_t                               q_item
);

    logic [stwalk_pkg::NumDims-1:0][EXTENT_BITS-1:0] idx_reg, idx_next, idx_step;
    logic [stwalk_pkg::CountW-1:0]                   count_reg, count_next;
    logic [stwalk_pkg::NumDims-1:0]                  wrap;
    logic [stwalk_pkg::NumDims-1:0]                  active;
    logic                                            last;
    logic                                            carry;
    stwalk_pkg::req_t                                kind;

    assign kind          = stwalk_pkg::req_t'(s_axis_tuser[0]);
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // Find the last element and step the multi-index, innermost dim first
    always_comb
    begin
        carry = 1'b1;
        for (int d = 0; d < stwalk_pkg::NumDims; d++)
        begin
            active[d] = (d < int'(rank));
            wrap[d]   = (idx_reg[d] == ext[d] - EXTENT_BITS'(1));
        end
        last = &(wrap | ~active);
        for (int d = stwalk_pkg::NumDims - 1; d >= 0; d--)
        begin
            idx_step[d] = idx_reg[d];
            if (active[d] && carry)
            begin
                if (wrap[d])
                begin
                    idx_step[d] = '0;
                end
                else
                begin
                    idx_step[d] = idx_reg[d] + EXTENT_BITS'(1);
                    carry       = 1'b0;
                end
            end
        end
    end

    // Classify the beat into a queue entry
    always_comb
    begin
        q_item.kind  = kind;
        q_item.count = count_reg;
        q_item.last  = last;
        for (int d = 0; d < stwalk_pkg::NumDims; d++)
        begin
            if (kind == stwalk_pkg::REQ_TRANSLATE)
            begin
                q_item.idx[d] = s_axis_tdata[stwalk_pkg::IdxW*d +: stwalk_pkg::IdxW];
            end
            else
            begin
                q_item.idx[d] = stwalk_pkg::IdxW'(idx_reg[d]);
            end
        end
    end

    // Restart on a register write, else advance the walk on a next request, wrap after the last element
    always_comb
    begin
        idx_next   = idx_reg;
        count_next = count_reg;
        if (restart)
        begin
            idx_next   = '0;
            count_next = '0;
        end
        else if (q_push && kind == stwalk_pkg::REQ_NEXT)
        begin
            if (last)
            begin
                idx_next   = '0;
                count_next = '0;
            end
            else
            begin
                idx_next   = idx_step;
                count_next = count_reg + stwalk_pkg::CountW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/stwalk_queue.sv */
`default_nettype none
module stwalk_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire stwalk_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output stwalk_pkg::item_t   head
);

    localparam int PtrW = $clog2(stwalk_pkg::QueueDepth);
    localparam int CntW = $clog2(stwalk_pkg::QueueDepth + 1);

    stwalk_pkg::item_t         entry_reg [stwalk_pkg::QueueDepth];
    logic [PtrW-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]           cnt_reg,    cnt_next;

    assign full  = (cnt_reg == CntW'(stwalk_pkg::QueueDepth));
    assign valid = (cnt_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Move pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(stwalk_pkg::QueueDepth - 1)) ? '0
                        : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(stwalk_pkg::QueueDepth - 1)) ? '0
                        : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/stwalk_back.sv */
`default_nettype none
module stwalk_back #(
    parameter int EXTENT_BITS = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       q_valid,
    input  wire stwalk_pkg::item_t                          q_item,
    output logic                                            q_pop,
    input  wire stwalk_pkg::cfg_t                           cfg,
    input  wire logic [stwalk_pkg::NumDims-1:0][EXTENT_BITS-1:0] ext,
    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,
    output logic [stwalk_pkg::OutDataW-1:0]                 m_axis_tdata,
    output logic [stwalk_pkg::OutUserW-1:0]                 m_axis_tuser,
    output logic                                            m_axis_tlast
);

    localparam int DstFullW = stwalk_pkg::CountW + stwalk_pkg::EszW;
    localparam int SrcFullW = stwalk_pkg::OffW + stwalk_pkg::EszW;

    // Stage 1: products and bounds
    logic                                                s1_valid_reg;
    stwalk_pkg::req_t                                    s1_kind_reg;
    logic                                                s1_last_reg;
    logic                                                s1_bad_reg,  s1_bad_next;
    logic [stwalk_pkg::NumDims-1:0][stwalk_pkg::ProdW-1:0] s1_prod_reg, s1_prod_next;
    logic [stwalk_pkg::DstW-1:0]                         s1_dst_reg,  s1_dst_next;
    logic [DstFullW-1:0]                                 dst_full;

    // Stage 2: offset sum
    logic                                                s2_valid_reg;
    stwalk_pkg::req_t                                    s2_kind_reg;
    logic                                                s2_last_reg;
    logic                                                s2_bad_reg;
    logic [stwalk_pkg::OffW-1:0]                         s2_off_reg,  s2_off_next;
    logic [stwalk_pkg::DstW-1:0]                         s2_dst_reg;

    // Output register
    logic                                                out_valid_reg;
    logic [stwalk_pkg::SrcW-1:0]                         out_src_reg, out_src_next;
    logic [stwalk_pkg::DstW-1:0]                         out_dst_reg, out_dst_next;
    logic [stwalk_pkg::OffW-1:0]                         out_off_reg, out_off_next;
    logic                                                out_last_reg, out_status_reg;
    logic                                                out_contig_reg;
    logic [SrcFullW-1:0]                                 src_full;

    logic                                                out_free, s2_free, s1_free;

    // Each stage moves when the one after it is empty or moving
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign q_pop    = q_valid && s1_free;

    // Index times stride per dimension in use, bounds check, destination address
    always_comb
    begin
        s1_bad_next = 1'b0;
        for (int d = 0; d < stwalk_pkg::NumDims; d++)
        begin
            s1_prod_next[d] = '0;
            if (d < int'(cfg.rank))
            begin
                s1_prod_next[d] = q_item.idx[d] * cfg.stride[d];
                if ({1'b0, q_item.idx[d]} >= (stwalk_pkg::IdxW + 1)'(ext[d]))
                begin
                    s1_bad_next = 1'b1;
                end
            end
        end
        dst_full    = q_item.count * cfg.esz;
        s1_dst_next = dst_full[stwalk_pkg::DstW-1:0];
    end

    // Sum the offset; the walk adds the base, a translate does not
    always_comb
    begin
        s2_off_next = stwalk_pkg::OffW'(s1_prod_reg[0])
                    + stwalk_pkg::OffW'(s1_prod_reg[1])
                    + stwalk_pkg::OffW'(s1_prod_reg[2]);
        if (s1_kind_reg == stwalk_pkg::REQ_NEXT)
        begin
            s2_off_next = s2_off_next + stwalk_pkg::OffW'(cfg.base);
        end
    end

    // Scale to bytes and zero the fields that do not apply
    always_comb
    begin
        src_full     = s2_off_reg * cfg.esz;
        out_src_next = '0;
        out_dst_next = '0;
        out_off_next = '0;
        if (s2_kind_reg == stwalk_pkg::REQ_NEXT)
        begin
            out_src_next = src_full[stwalk_pkg::SrcW-1:0];
            out_dst_next = s2_dst_reg;
        end
        else if (!s2_bad_reg)
        begin
            out_off_next = s2_off_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= q_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload moves with its valid bit
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_kind_reg <= q_item.kind;
            s1_last_reg <= q_item.last;
            s1_bad_reg  <= s1_bad_next;
            s1_prod_reg <= s1_prod_next;
            s1_dst_reg  <= s1_dst_next;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_last_reg <= s1_last_reg;
            s2_bad_reg  <= s1_bad_reg;
            s2_off_reg  <= s2_off_next;
            s2_dst_reg  <= s1_dst_reg;
        end
        if (out_free && s2_valid_reg)
        begin
            out_src_reg    <= out_src_next;
            out_dst_reg    <= out_dst_next;
            out_off_reg    <= out_off_next;
            out_last_reg   <= (s2_kind_reg == stwalk_pkg::REQ_NEXT) && s2_last_reg;
            out_status_reg <= (s2_kind_reg == stwalk_pkg::REQ_TRANSLATE) && s2_bad_reg;
            out_contig_reg <= cfg.contig;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_contig_reg, out_status_reg};
    assign m_axis_tdata  = {
        (stwalk_pkg::OutDataW - stwalk_pkg::OffW - stwalk_pkg::DstW - stwalk_pkg::SrcW)'(0),
        out_off_reg, out_dst_reg, out_src_reg
    };

endmodule
`default_nettype wire

/* rtl/strided_tensor_address_walker_unit.sv */
// Channel      Direction  Handshake                    Payload
// s_axis       in         s_axis_tvalid/s_axis_tready  tdata idx_0..idx_2, tuser req_type
// m_axis       out        m_axis_tvalid/m_axis_tready  tdata src/dst/offset, tuser, tlast
// apb          in         psel/penable, pready = 1     7 registers at 8*i, 64-bit data
//
// One request per cycle sustained while m_axis_tready holds high; an accepted beat passes
// the queue, product stage, sum stage and output register before its result appears.
// The widest step is one 16x32 multiply per dimension in the product stage.
// Reset clears the walk to the first element and loads the register defaults.
// A two-entry queue parts the front from the back; a stalled output holds the
// back pipeline and then fills the queue before s_axis_tready drops.
`default_nettype none
module strided_tensor_address_walker_unit #(
    parameter int EXTENT_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [stwalk_pkg::CfgAddrW-1:0]        paddr,
    input  wire logic [stwalk_pkg::CfgDataW-1:0]        pwdata,
    output logic      [stwalk_pkg::CfgDataW-1:0]        prdata,
    output logic                                        pready,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // idx_0 [15:0], idx_1 [31:16], idx_2 [47:32]
    input  wire logic [stwalk_pkg::InDataW-1:0]         s_axis_tdata,
    // req_type [0]
    input  wire logic [0:0]                             s_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // src_byte_addr [52:0], dst_byte_addr [103:53], element_offset [153:104], zero [159:154]
    output logic [stwalk_pkg::OutDataW-1:0]             m_axis_tdata,
    // index_status [0], contiguous [1]
    output logic [stwalk_pkg::OutUserW-1:0]             m_axis_tuser,
    // last_element
    output logic                                        m_axis_tlast
);

    stwalk_pkg::cfg_t                                   cfg;
    logic [stwalk_pkg::NumDims-1:0][EXTENT_BITS-1:0]    ext;
    logic                                               restart;
    logic                                               q_push, q_full, q_pop, q_valid;
    stwalk_pkg::item_t                                  push_item, head_item;

    assign pready = 1'b1;

    stwalk_cfg #(
        .EXTENT_BITS (EXTENT_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .ext     (ext),
        .restart (restart)
    );

    stwalk_front #(
        .EXTENT_BITS (EXTENT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .rank          (cfg.rank),
        .ext           (ext),
        .restart       (restart),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    stwalk_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    stwalk_back #(
        .EXTENT_BITS (EXTENT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .cfg           (cfg),
        .ext           (ext),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

/* tb/strided_tensor_address_walker_unit_tb.sv */
module strided_tensor_address_walker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stwalk_pkg::*;

    localparam int GapMax       = 18;
    localparam int HoldCycles   = 150;
    localparam int DrainCycles  = 8;
    localparam int PhaseItems   = 140;
    localparam int RandomPhases = 14;
    localparam int PressurePhase = 3;
    localparam int ReportLimit  = 10;
    localparam logic [2:0] RegSpare = 3'd7;

    // One result beat split into its fields
    typedef struct packed {
        logic [SrcW-1:0] src;
        logic [DstW-1:0] dst;
        logic            last;
        logic [OffW-1:0] offset;
        logic            status;
        logic            contig;
    } walk_result_t;

    // Address predictor plus the queue of results still owed by the block
    class walk_scoreboard;
        logic [RankW-1:0]   rank;
        logic [EszW-1:0]    esz_raw;
        logic [BaseW-1:0]   base;
        logic [ExtRegW-1:0] extents;
        logic [StrideW-1:0] stride [NumDims];
        logic [IdxW-1:0]    pos [NumDims];
        logic [CountW-1:0]  count;
        walk_result_t       owed_q [$];
        int unsigned        errors;
        int unsigned        n_next;
        int unsigned        n_translate;
        int unsigned        n_wrap;
        int unsigned        n_oob;

        function new();
            rank = RankRst;
            esz_raw = ElemRst;
            base = '0;
            extents = ExtentsRst;
            foreach (stride[d]) stride[d] = StrideRst;
            restart();
            errors = 0;
            n_next = 0;
            n_translate = 0;
            n_wrap = 0;
            n_oob = 0;
        endfunction

        function void restart();
            foreach (pos[d]) pos[d] = '0;
            count = '0;
        endfunction

        // Zero extent counts as one
        function logic [63:0] extent(int unsigned d);
            logic [ExtFieldW-1:0] e;
            e = extents[ExtFieldW*d +: ExtFieldW];
            return (e == '0) ? 64'd1 : 64'(e);
        endfunction

        // Clamp element size into 1..8
        function logic [63:0] elem_size();
            if (esz_raw == '0)
                return 64'd1;
            if (esz_raw > 4'd8)
                return 64'd8;
            return 64'(esz_raw);
        endfunction

        function logic strides_row_major();
            logic [63:0] want;
            want = 64'd1;
            for (int d = int'(rank) - 1; d >= 0; d--)
            begin
                if (64'(stride[d]) != want)
                    return 1'b0;
                want = want * extent(d);
            end
            return 1'b1;
        endfunction

        function logic [OffW-1:0] walk_offset();
            logic [63:0] acc;
            acc = 64'(base);
            for (int d = 0; d < int'(rank); d++)
                acc += 64'(pos[d]) * 64'(stride[d]);
            return acc[OffW-1:0];
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_RANK:       rank = value[RankW-1:0];
                REG_ELEM_BYTES: esz_raw = value[EszW-1:0];
                REG_BASE:       base = value[BaseW-1:0];
                REG_EXTENTS:    extents = value[ExtRegW-1:0];
                REG_STRIDE0:    stride[0] = value[StrideW-1:0];
                REG_STRIDE1:    stride[1] = value[StrideW-1:0];
                REG_STRIDE2:    stride[2] = value[StrideW-1:0];
                default:        return;
            endcase
            restart();
        endfunction

        // Predict the result of one accepted request beat
        function void note_request(req_t kind, logic [IdxW-1:0] i0, logic [IdxW-1:0] i1,
                                   logic [IdxW-1:0] i2);
            walk_result_t r;
            logic [IdxW-1:0] ix [NumDims];
            logic [63:0] acc;
            logic [63:0] total;
            logic [63:0] esz;
            logic bad;
            int d;
            r = '0;
            r.contig = strides_row_major();
            esz = elem_size();
            ix[0] = i0;
            ix[1] = i1;
            ix[2] = i2;
            if (kind == REQ_TRANSLATE)
            begin
                n_translate++;
                acc = '0;
                bad = 1'b0;
                for (d = 0; d < int'(rank); d++)
                begin
                    if (64'(ix[d]) >= extent(d))
                        bad = 1'b1;
                    acc += 64'(ix[d]) * 64'(stride[d]);
                end
                r.status = bad;
                r.offset = bad ? '0 : acc[OffW-1:0];
                if (bad)
                    n_oob++;
            end
            else
            begin
                n_next++;
                total = 64'd1;
                for (d = 0; d < int'(rank); d++)
                    total = total * extent(d);
                acc = 64'(walk_offset()) * esz;
                r.src = acc[SrcW-1:0];
                acc = 64'(count) * esz;
                r.dst = acc[DstW-1:0];
                r.last = (64'(count) + 64'd1 >= total);
                if (r.last)
                begin
                    n_wrap++;
                    restart();
                end
                else
                begin
                    // Advance the multi-index, last dimension in use fastest
                    count = count + 1'b1;
                    d = int'(rank);
                    while (d > 0)
                    begin
                        d--;
                        pos[d] = pos[d] + 1'b1;
                        if (64'(pos[d]) < extent(d))
                            break;
                        pos[d] = '0;
                    end
                end
            end
            owed_q.push_back(r);
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_result(logic [OutDataW-1:0] data, logic [OutUserW-1:0] user,
                                   logic last);
            walk_result_t got;
            walk_result_t want;
            logic [OutDataW-SrcW-DstW-OffW-1:0] pad;
            got.src = data[SrcW-1:0];
            got.dst = data[SrcW +: DstW];
            got.offset = data[SrcW+DstW +: OffW];
            got.last = last;
            got.status = user[0];
            got.contig = user[1];
            pad = data[OutDataW-1:SrcW+DstW+OffW];
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= ReportLimit)
                    $display("ERROR: result beat with nothing owed: src=%h dst=%h last=%b",
                             got.src, got.dst, got.last);
                return;
            end
            want = owed_q.pop_front();
            if (got !== want || pad !== '0)
            begin
                errors++;
                if (errors <= ReportLimit)
                begin
                    $display("ERROR: exp src=%h dst=%h last=%b off=%h st=%b ctg=%b",
                             want.src, want.dst, want.last, want.offset, want.status,
                             want.contig);
                    $display("       got src=%h dst=%h last=%b off=%h st=%b ctg=%b pad=%h",
                             got.src, got.dst, got.last, got.offset, got.status,
                             got.contig, pad);
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CfgAddrW-1:0]    paddr;
    logic [CfgDataW-1:0]    pwdata;
    logic [CfgDataW-1:0]    prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [InDataW-1:0]     s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OutDataW-1:0]    m_axis_tdata;
    logic [OutUserW-1:0]    m_axis_tuser;
    logic                   m_axis_tlast;

    walk_scoreboard sb;
    int unsigned    src_gap_max;
    int unsigned    sink_stall_max;
    bit             hold_off_req;
    int unsigned    n_settings;

    strided_tensor_address_walker_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Predict on every accepted request beat, check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(req_t'(s_axis_tuser[0]), s_axis_tdata[IdxW-1:0],
                            s_axis_tdata[IdxW +: IdxW], s_axis_tdata[2*IdxW +: IdxW]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Result sink: random stalls per beat, one long hold-off on request
    initial
    begin : sink
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                stall = HoldCycles;
                hold_off_req = 1'b0;
            end
            else
                stall = $urandom_range(0, sink_stall_max);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        sb.write_reg(idx, value);
    endtask

    // Offer one request beat after a random gap; return at the falling edge after it
    task automatic send_req(req_t kind, logic [IdxW-1:0] i0, logic [IdxW-1:0] i1,
                            logic [IdxW-1:0] i2);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {i2, i1, i0};
        s_axis_tuser <= kind;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // Mostly walk steps; translates mix in-range, boundary and wild indices
    task automatic random_req();
        logic [IdxW-1:0] ix [NumDims];
        logic [63:0] ext;
        int unsigned sel;
        if ($urandom_range(0, 9) < 7)
            send_req(REQ_NEXT, 16'($urandom), 16'($urandom), 16'($urandom));
        else
        begin
            for (int d = 0; d < NumDims; d++)
            begin
                ext = sb.extent(d);
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    ix[d] = 16'($urandom_range(0, 32'(ext - 64'd1)));
                else if (sel < 7)
                    ix[d] = ext[IdxW-1:0];
                else
                    ix[d] = 16'($urandom);
            end
            send_req(REQ_TRANSLATE, ix[0], ix[1], ix[2]);
        end
    endtask

    // Upper bits beyond a register's width are junk the block must drop
    function automatic logic [63:0] junk_above(logic [63:0] v, int w, bit noisy);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        return noisy ? (v | (junk << w)) : v;
    endfunction

    task automatic random_config();
        logic [ExtFieldW-1:0] ext [NumDims];
        logic [StrideW-1:0] str [NumDims];
        logic [63:0] want;
        logic [63:0] wide;
        logic [1:0] rank;
        logic [3:0] esz;
        logic [BaseW-1:0] base;
        int unsigned sel;
        bit noisy;
        noisy = ($urandom_range(0, 3) == 0);
        rank = 2'($urandom_range(0, 3));
        esz = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 8)) : 4'($urandom);
        wide = {$urandom, $urandom};
        sel = $urandom_range(0, 7);
        base = (sel == 0) ? '0 : (sel == 1) ? '1 : wide[BaseW-1:0];
        for (int d = 0; d < NumDims; d++)
        begin
            sel = $urandom_range(0, 19);
            ext[d] = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
                     (sel == 2) ? 16'($urandom) : 16'($urandom_range(1, 4));
        end
        sel = $urandom_range(0, 2);
        for (int d = 0; d < NumDims; d++)
            str[d] = (sel == 1) ? 32'($urandom_range(0, 9)) :
                     ($urandom_range(0, 3) == 0) ? '1 : 32'($urandom);
        // Row-major packed strides for the dimensions in use
        if (sel == 0)
        begin
            want = 64'd1;
            for (int d = int'(rank) - 1; d >= 0; d--)
            begin
                str[d] = want[StrideW-1:0];
                want = want * ((ext[d] == '0) ? 64'd1 : 64'(ext[d]));
            end
        end
        apb_write(REG_RANK, junk_above(64'(rank), RankW, noisy));
        apb_write(REG_ELEM_BYTES, junk_above(64'(esz), EszW, noisy));
        apb_write(REG_BASE, junk_above(64'(base), BaseW, noisy));
        apb_write(REG_EXTENTS, junk_above(64'({ext[2], ext[1], ext[0]}), ExtRegW, noisy));
        apb_write(REG_STRIDE0, junk_above(64'(str[0]), StrideW, noisy));
        apb_write(REG_STRIDE1, junk_above(64'(str[1]), StrideW, noisy));
        apb_write(REG_STRIDE2, junk_above(64'(str[2]), StrideW, noisy));
        n_settings++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        hold_off_req = 1'b0;
        n_settings = 1;
        src_gap_max = GapMax;
        sink_stall_max = GapMax;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset layout: one element, unused indices ignored, out-of-range indices
        send_req(REQ_NEXT, '0, '0, '0);
        send_req(REQ_TRANSLATE, 16'd0, 16'hFFFF, 16'hFFFF);
        send_req(REQ_TRANSLATE, 16'd1, 16'd0, 16'd0);
        send_req(REQ_TRANSLATE, 16'hFFFF, 16'd0, 16'd0);
        drain();

        // Rank three, saturated element size, largest base and strides, zero extent
        apb_write(REG_RANK, '1);
        apb_write(REG_ELEM_BYTES, '1);
        apb_write(REG_BASE, 64'hFF_FFFF_FFFF);
        apb_write(REG_EXTENTS, 64'h0000_0003_0002);
        apb_write(REG_STRIDE0, 64'hFFFF_FFFF);
        apb_write(REG_STRIDE1, 64'hFFFF_FFFF);
        apb_write(REG_STRIDE2, 64'hFFFF_FFFF);
        n_settings++;
        repeat (7) send_req(REQ_NEXT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_req(REQ_TRANSLATE, 16'd1, 16'd2, 16'd0);
        send_req(REQ_TRANSLATE, 16'd2, 16'd0, 16'd0);
        send_req(REQ_TRANSLATE, 16'd0, 16'd0, 16'd1);
        drain();

        // Write past the register list: walk must carry on
        apb_write(RegSpare, '1);
        send_req(REQ_NEXT, '0, '0, '0);
        drain();

        // Scalar tensor with element size zero
        apb_write(REG_RANK, 64'd0);
        apb_write(REG_ELEM_BYTES, 64'd0);
        apb_write(REG_EXTENTS, 64'hFFFF_FFFF_FFFF);
        apb_write(REG_STRIDE0, 64'd0);
        apb_write(REG_STRIDE1, 64'd0);
        apb_write(REG_STRIDE2, 64'd0);
        n_settings++;
        send_req(REQ_NEXT, '0, '0, '0);
        send_req(REQ_NEXT, '0, '0, '0);
        send_req(REQ_TRANSLATE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();

        // Contiguous 4x3 matrix
        apb_write(REG_RANK, 64'd2);
        apb_write(REG_ELEM_BYTES, 64'd1);
        apb_write(REG_BASE, 64'd0);
        apb_write(REG_EXTENTS, 64'h0009_0003_0004);
        apb_write(REG_STRIDE0, 64'd3);
        apb_write(REG_STRIDE1, 64'd1);
        apb_write(REG_STRIDE2, 64'd7);
        n_settings++;
        repeat (4) send_req(REQ_NEXT, '0, '0, '0);
        send_req(REQ_TRANSLATE, 16'd3, 16'd2, 16'hFFFF);
        send_req(REQ_TRANSLATE, 16'd4, 16'd0, 16'd0);
        drain();

        // Random settings, each followed by a burst of mixed requests
        for (int ph = 0; ph < RandomPhases; ph++)
        begin
            random_config();
            src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GapMax;
            sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : GapMax;
            if (ph == PressurePhase)
            begin
                src_gap_max = 0;
                hold_off_req = 1'b1;
            end
            repeat (PhaseItems) random_req();
            drain();
        end

        $display("Covered %0d walk steps with %0d wraps and %0d translates, %0d out of bounds,",
                 sb.n_next, sb.n_wrap, sb.n_translate, sb.n_oob);
        $display("over %0d register settings with random gaps on both sides and one long stall.",
                 n_settings);
        sb.errors += sb.owed_q.size();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Timeout with %0d results still owed", sb.owed_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
